// ===== sv/spls_pkg.sv =====
// shared types, constants and tap weight tables of the seven-point smoother
// depends on nothing; used by the cell, divider and top level
`default_nettype none

package spls_pkg;

   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int TAPS                = 7;

   // growth over the sample width: product with a weight, sum of seven, divider magnitude
   localparam int TERM_GROWTH = 4;
   localparam int SUM_GROWTH  = 6;
   localparam int MAG_GROWTH  = 3;

   // output positions of one window, in emission order
   localparam logic [2:0] OP_HEAD0 = 3'd0;
   localparam logic [2:0] OP_HEAD1 = 3'd1;
   localparam logic [2:0] OP_HEAD2 = 3'd2;
   localparam logic [2:0] OP_MEAN  = 3'd3;
   localparam logic [2:0] OP_TAIL2 = 3'd4;
   localparam logic [2:0] OP_TAIL1 = 3'd5;
   localparam logic [2:0] OP_TAIL0 = 3'd6;

   localparam logic [2:0] LAST_TAP  = 3'd6;
   localparam logic [2:0] SEEN_FULL = 3'd7;

   // divisor selects
   localparam logic [1:0] DIV_ONE          = 2'd0;
   localparam logic [1:0] DIV_SEVEN        = 2'd1;
   localparam logic [1:0] DIV_FOURTEEN     = 2'd2;
   localparam logic [1:0] DIV_TWENTYEIGHT  = 2'd3;

   typedef logic signed [4:0] weight_type;

   typedef struct packed {
      logic [1:0] div_sel;
      logic       last;
   } meta_type;

   localparam weight_type HEAD0_W [TAPS] = '{5'sd13, 5'sd10, 5'sd7, 5'sd4, 5'sd1, -5'sd2, -5'sd5};
   localparam weight_type HEAD1_W [TAPS] = '{5'sd5, 5'sd4, 5'sd3, 5'sd2, 5'sd1, 5'sd0, -5'sd1};
   localparam weight_type HEAD2_W [TAPS] = '{5'sd7, 5'sd6, 5'sd5, 5'sd4, 5'sd3, 5'sd2, 5'sd1};

   // weight of window tap (0 = oldest) for an output position; tail outputs mirror the head
   function automatic weight_type tap_weight(input logic [2:0] op, input logic [2:0] tap);
      logic [2:0] idx;
      weight_type w;
      idx = (op > OP_MEAN) ? (LAST_TAP - tap) : tap;
      case (op) inside
         OP_HEAD0, OP_TAIL0: w = HEAD0_W[idx];
         OP_HEAD1, OP_TAIL1: w = HEAD1_W[idx];
         OP_HEAD2, OP_TAIL2: w = HEAD2_W[idx];
         OP_MEAN:            w = 5'sd1;
         default:            w = 5'sd0;
      endcase
      return w;
   endfunction

   function automatic logic [1:0] op_divisor(input logic [2:0] op);
      logic [1:0] d;
      case (op) inside
         OP_HEAD1, OP_TAIL1: d = DIV_FOURTEEN;
         OP_MEAN:            d = DIV_SEVEN;
         default:            d = DIV_TWENTYEIGHT;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

// ===== sv/seven_point_linear_smoother.sv =====
// seven-point linear smoother, top level: window cells, output sequencer, sum stage
// depends on spls_pkg, spls_cell and spls_divider
//
// usage
//   req_ channel: one signed sample per beat, req_tlast on the last sample of a frame
//   rsp_ channel: smoothed samples in frame order, rsp_tlast on the final one of a frame
//   a frame of seven or more samples: the seventh beat yields outputs 0 to 3, each
//   later beat yields one centered mean, the last beat adds the three tail outputs
//   a frame shorter than seven is held and given back unchanged on its last beat
// throughput: one beat per cycle in steady state while rsp_ keeps up; a beat that yields
//   more than one result holds req_tready low until the output sequencer has read the
//   last owed position; it reads one window position per cycle while stage 1 can take it
// path: a result reaches rsp_ through the registers for the weighted terms, sum, magnitude,
//   reciprocal product, quotient, and correction and output register
// reset: synchronous, clears the frame count and all stage valids; window contents
//   need no clearing since only samples of the current frame are read
// stall: the pipeline stages fill up behind a stalled rsp_ channel before req_tready
//   drops, so the sample side keeps moving for a few beats
`default_nettype none

module seven_point_linear_smoother #(
   parameter int SAMPLE_BITS = spls_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: sample [SAMPLE_BITS-1:0], zero fill up to a whole byte
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]     req_tdata,
   input  logic                                 req_tlast,   // frame_end
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // rsp_tdata: smoothed [SAMPLE_BITS-1:0], zero fill up to a whole byte
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]     rsp_tdata,
   output logic                                 rsp_tlast,   // run_last
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready
);
   import spls_pkg::*;

   localparam int DW = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int TW = SAMPLE_BITS + TERM_GROWTH;
   localparam int SW = SAMPLE_BITS + SUM_GROWTH;

   logic signed [SAMPLE_BITS-1:0] req_sample;
   logic                          req_accept;
   logic                          issue, issue_done;
   logic                          rdy_s1, rdy_s2, div_ready;

   assign req_sample = req_tdata[SAMPLE_BITS-1:0];

   // output sequencer: walks the positions still owed by the current window
   logic [2:0] seen_ff, seen_in, seen_inc;
   logic       busy_ff, busy_in;
   logic       pass_ff, pass_in;
   logic [2:0] pos_ff, pos_in;
   logic [2:0] end_ff, end_in;
   logic       last_ff, last_in;

   assign issue      = busy_ff && rdy_s1;
   assign issue_done = issue && (pos_ff == end_ff);
   assign req_tready = !busy_ff || issue_done;
   assign req_accept = req_tvalid && req_tready;
   assign seen_inc   = (seen_ff == SEEN_FULL) ? SEEN_FULL : seen_ff + 3'd1;

   always_comb begin
      seen_in = seen_ff;
      busy_in = busy_ff;
      pass_in = pass_ff;
      pos_in  = pos_ff;
      end_in  = end_ff;
      last_in = last_ff;
      if (issue) begin
         if (pos_ff == end_ff) begin
            busy_in = 1'b0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
      if (req_accept) begin
         last_in = req_tlast;
         seen_in = req_tlast ? 3'd0 : seen_inc;
         if (seen_inc != SEEN_FULL) begin
            // short frame: hand back the held samples, oldest first
            if (req_tlast) begin
               busy_in = 1'b1;
               pass_in = 1'b1;
               pos_in  = SEEN_FULL - seen_inc;
               end_in  = LAST_TAP;
            end
         end else begin
            busy_in = 1'b1;
            pass_in = 1'b0;
            pos_in  = (seen_ff != SEEN_FULL) ? OP_HEAD0 : OP_MEAN;
            end_in  = req_tlast ? OP_TAIL0 : OP_MEAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 3'd0;
         busy_ff <= 1'b0;
         pass_ff <= 1'b0;
         pos_ff  <= OP_HEAD0;
         end_ff  <= OP_HEAD0;
         last_ff <= 1'b0;
      end else begin
         seen_ff <= seen_in;
         busy_ff <= busy_in;
         pass_ff <= pass_in;
         pos_ff  <= pos_in;
         end_ff  <= end_in;
         last_ff <= last_in;
      end
   end

   // window cells, tap 0 oldest; a new sample enters at the last tap
   logic signed [SAMPLE_BITS-1:0] samp_w [TAPS];
   logic signed [TW-1:0]          term_w [TAPS];
   weight_type                    weight_w [TAPS];

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         if (pass_ff) begin
            weight_w[i] = (pos_ff == 3'(i)) ? 5'sd1 : 5'sd0;
         end else begin
            weight_w[i] = tap_weight(pos_ff, 3'(i));
         end
      end
   end

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      logic signed [SAMPLE_BITS-1:0] feed_w;
      if (i == TAPS - 1) begin : g_head
         assign feed_w = req_sample;
      end else begin : g_body
         assign feed_w = samp_w[i+1];
      end
      spls_cell #(
         .SAMPLE_BITS (SAMPLE_BITS)
      ) u_cell (
         .clock      (clock),
         .shift_en   (req_accept),
         .sample_in  (feed_w),
         .sample_out (samp_w[i]),
         .term_en    (issue),
         .weight     (weight_w[i]),
         .term_out   (term_w[i])
      );
   end

   // stage 1 valid and meta travel beside the cell terms
   logic     s1_valid_ff, s1_valid_in;
   meta_type s1_meta_ff, s1_meta_in;

   assign s1_valid_in = rdy_s1 ? issue : s1_valid_ff;

   always_comb begin
      s1_meta_in = s1_meta_ff;
      if (issue) begin
         s1_meta_in.div_sel = pass_ff ? DIV_ONE : op_divisor(pos_ff);
         s1_meta_in.last    = last_ff && (pos_ff == end_ff);
      end
   end

   // stage 2: sum of the seven weighted terms
   logic                 s2_valid_ff, s2_valid_in;
   meta_type             s2_meta_ff, s2_meta_in;
   logic signed [SW-1:0] s2_sum_ff, s2_sum_in, sum_w;

   assign sum_w = ((SW'(term_w[0]) + SW'(term_w[1])) + (SW'(term_w[2]) + SW'(term_w[3])))
                + ((SW'(term_w[4]) + SW'(term_w[5])) + SW'(term_w[6]));

   assign s2_valid_in = rdy_s2 ? s1_valid_ff : s2_valid_ff;
   assign s2_meta_in  = rdy_s2 ? s1_meta_ff : s2_meta_ff;
   assign s2_sum_in   = rdy_s2 ? sum_w : s2_sum_ff;

   assign rdy_s2 = !s2_valid_ff || div_ready;
   assign rdy_s1 = !s1_valid_ff || rdy_s2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      s1_meta_ff <= s1_meta_in;
      s2_meta_ff <= s2_meta_in;
      s2_sum_ff  <= s2_sum_in;
   end

   // divide, round toward zero, saturate, output register
   logic [SAMPLE_BITS-1:0] rsp_value;

   spls_divider #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid_ff),
      .in_ready  (div_ready),
      .in_sum    (s2_sum_ff),
      .in_meta   (s2_meta_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_value (rsp_value),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = DW'(rsp_value);

   // sequencer never runs past the last owed position
   a_pos_order: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (pos_ff <= end_ff))
      else $error("output position beyond end of window");

   // a new beat shifts the window only once the last owed position has been read
   a_accept_final: assert property (@(posedge clock) disable iff (reset)
      (req_accept && busy_ff) |-> (pos_ff == end_ff))
      else $error("window shifted while outputs still owed");

   // frame end restarts the sample count
   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_tlast) |=> (seen_ff == 3'd0))
      else $error("frame count not cleared after frame end");

   // short frame hand-back starts past the oldest tap and ends on the newest
   a_pass_span: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && pass_ff) |-> ((pos_ff != 3'd0) && (end_ff == LAST_TAP)))
      else $error("short frame span out of range");

endmodule

`default_nettype wire

// ===== sv/spls_cell.sv =====
// one window cell: holds a sample, hands it to the older neighbor, weights it
// depends on spls_pkg
`default_nettype none

module spls_cell #(
   parameter int SAMPLE_BITS = spls_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                             clock,
   input  logic                                             shift_en,
   input  logic signed [SAMPLE_BITS-1:0]                    sample_in,
   output logic signed [SAMPLE_BITS-1:0]                    sample_out,
   input  logic                                             term_en,
   input  spls_pkg::weight_type                             weight,
   output logic signed [SAMPLE_BITS+spls_pkg::TERM_GROWTH-1:0] term_out
);
   import spls_pkg::*;

   localparam int TW = SAMPLE_BITS + TERM_GROWTH;

   logic signed [SAMPLE_BITS-1:0] sample_ff, sample_in_w;
   logic signed [TW-1:0]          term_ff, term_in, prod_w;

   assign sample_in_w = shift_en ? sample_in : sample_ff;
   // zero weight gives a zero term, so taps never loaded since reset stay out of the sum
   assign prod_w      = (weight == '0) ? '0 : (TW'(sample_ff) * TW'(weight));
   assign term_in     = term_en ? prod_w : term_ff;

   always_ff @(posedge clock) begin
      sample_ff <= sample_in_w;
      term_ff   <= term_in;
   end

   assign sample_out = sample_ff;
   assign term_out   = term_ff;

endmodule

`default_nettype wire

// ===== sv/spls_divider.sv =====
// signed divide by 1, 7, 14 or 28 with truncation toward zero and output saturation
// four stages: magnitude, split reciprocal product, quotient, correction; depends on spls_pkg
`default_nettype none

module spls_divider #(
   parameter int SAMPLE_BITS = spls_pkg::SAMPLE_BITS_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  logic signed [SAMPLE_BITS+spls_pkg::SUM_GROWTH-1:0] in_sum,
   input  spls_pkg::meta_type                                 in_meta,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output logic [SAMPLE_BITS-1:0]                             out_value,
   output logic                                               out_last
);
   import spls_pkg::*;

   localparam int SW = SAMPLE_BITS + SUM_GROWTH;
   localparam int W  = SAMPLE_BITS + MAG_GROWTH;   // magnitude width
   localparam int RW = W - 2;                      // reciprocal and quotient width
   localparam int HW = (W + 1) / 2;                // low half of the magnitude
   localparam int LW = W - HW;                     // high half
   localparam logic [RW-1:0] RECIP   = RW'((64'd1 << W) / 64'd7);
   localparam logic [RW-1:0] POS_MAX = RW'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
   localparam logic [RW-1:0] NEG_LIM = RW'(64'd1 << (SAMPLE_BITS - 1));

   logic rdy_a, rdy_b, rdy_c, rdy_o;

   // stage a: sign and pre-shifted magnitude
   logic [SW-1:0] abs_w;
   logic [W-1:0]  mag_w;
   logic          a_valid_ff, a_valid_in, a_neg_ff, a_neg_in;
   logic [W-1:0]  a_mag_ff, a_mag_in;
   meta_type      a_meta_ff, a_meta_in;

   assign abs_w = in_sum[SW-1] ? SW'(-in_sum) : SW'(in_sum);

   always_comb begin
      case (in_meta.div_sel)
         DIV_TWENTYEIGHT: mag_w = W'(abs_w >> 2);
         DIV_FOURTEEN:    mag_w = W'(abs_w >> 1);
         default:         mag_w = W'(abs_w);
      endcase
   end

   assign a_valid_in = rdy_a ? in_valid : a_valid_ff;
   assign a_neg_in   = rdy_a ? in_sum[SW-1] : a_neg_ff;
   assign a_mag_in   = rdy_a ? mag_w : a_mag_ff;
   assign a_meta_in  = rdy_a ? in_meta : a_meta_ff;

   // stage b: partial products of magnitude and reciprocal
   logic                 b_valid_ff, b_valid_in, b_neg_ff, b_neg_in;
   logic [W-1:0]         b_mag_ff, b_mag_in;
   meta_type             b_meta_ff, b_meta_in;
   logic [HW+RW-1:0]     b_lo_ff, b_lo_in;
   logic [LW+RW-1:0]     b_hi_ff, b_hi_in;

   assign b_valid_in = rdy_b ? a_valid_ff : b_valid_ff;
   assign b_neg_in   = rdy_b ? a_neg_ff : b_neg_ff;
   assign b_mag_in   = rdy_b ? a_mag_ff : b_mag_ff;
   assign b_meta_in  = rdy_b ? a_meta_ff : b_meta_ff;
   assign b_lo_in    = rdy_b ? ((HW+RW)'(a_mag_ff[HW-1:0]) * (HW+RW)'(RECIP)) : b_lo_ff;
   assign b_hi_in    = rdy_b ? ((LW+RW)'(a_mag_ff[W-1:HW]) * (LW+RW)'(RECIP)) : b_hi_ff;

   // stage c: quotient estimate, low or exact
   logic [W+RW-1:0] prod_w;
   logic            c_valid_ff, c_valid_in, c_neg_ff, c_neg_in;
   logic [W-1:0]    c_mag_ff, c_mag_in;
   meta_type        c_meta_ff, c_meta_in;
   logic [RW-1:0]   c_q0_ff, c_q0_in;

   assign prod_w     = ((W+RW)'(b_hi_ff) << HW) + (W+RW)'(b_lo_ff);
   assign c_valid_in = rdy_c ? b_valid_ff : c_valid_ff;
   assign c_neg_in   = rdy_c ? b_neg_ff : c_neg_ff;
   assign c_mag_in   = rdy_c ? b_mag_ff : c_mag_ff;
   assign c_meta_in  = rdy_c ? b_meta_ff : c_meta_ff;
   assign c_q0_in    = rdy_c ? prod_w[W+RW-1:W] : c_q0_ff;

   // output stage: one correction step, sign, saturation
   logic [W:0]             rem_w;
   logic [RW-1:0]          q_w;
   logic [SAMPLE_BITS-1:0] res_w;
   logic                   out_valid_ff, out_valid_in, out_last_ff, out_last_in;
   logic [SAMPLE_BITS-1:0] out_value_ff, out_value_in;

   assign rem_w = (W+1)'(c_mag_ff) - ((W+1)'(c_q0_ff) << 3) + (W+1)'(c_q0_ff);

   always_comb begin
      if (c_meta_ff.div_sel == DIV_ONE) begin
         q_w = c_mag_ff[RW-1:0];
      end else if (rem_w >= (W+1)'(7)) begin
         q_w = c_q0_ff + RW'(1);
      end else begin
         q_w = c_q0_ff;
      end
      if (c_neg_ff) begin
         res_w = (q_w > NEG_LIM) ? SAMPLE_BITS'(NEG_LIM) : SAMPLE_BITS'(-q_w);
      end else begin
         res_w = (q_w > POS_MAX) ? SAMPLE_BITS'(POS_MAX) : SAMPLE_BITS'(q_w);
      end
   end

   assign out_valid_in = rdy_o ? c_valid_ff : (out_valid_ff && !out_ready);
   assign out_value_in = (rdy_o && c_valid_ff) ? res_w : out_value_ff;
   assign out_last_in  = (rdy_o && c_valid_ff) ? c_meta_ff.last : out_last_ff;

   // ready chain, output end first; a stage loads when empty or when it moves on
   assign rdy_o    = !out_valid_ff || out_ready;
   assign rdy_c    = !c_valid_ff || rdy_o;
   assign rdy_b    = !b_valid_ff || rdy_c;
   assign rdy_a    = !a_valid_ff || rdy_b;
   assign in_ready = rdy_a;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         c_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         c_valid_ff   <= c_valid_in;
         out_valid_ff <= out_valid_in;
      end
      a_neg_ff     <= a_neg_in;
      a_mag_ff     <= a_mag_in;
      a_meta_ff    <= a_meta_in;
      b_neg_ff     <= b_neg_in;
      b_mag_ff     <= b_mag_in;
      b_meta_ff    <= b_meta_in;
      b_lo_ff      <= b_lo_in;
      b_hi_ff      <= b_hi_in;
      c_neg_ff     <= c_neg_in;
      c_mag_ff     <= c_mag_in;
      c_meta_ff    <= c_meta_in;
      c_q0_ff      <= c_q0_in;
      out_value_ff <= out_value_in;
      out_last_ff  <= out_last_in;
   end

   assign out_valid = out_valid_ff;
   assign out_value = out_value_ff;
   assign out_last  = out_last_ff;

endmodule

`default_nettype wire

// ===== test/tb_seven_point_linear_smoother.sv =====
// self-checking bench for the seven-point linear smoother: frames of samples in, smoothed frames out
// holds its own bit-exact predictor of the smoother; depends only on the block and its package
`timescale 1ns / 1ps

module tb_seven_point_linear_smoother;

   localparam int SBITS       = 16;
   localparam int DATA_W      = ((SBITS + 7) / 8) * 8;
   localparam int TAPS        = 7;
   localparam int QUIET_ITEMS = 50;     // the last beats go without any idling
   localparam int WD_LIMIT    = 2000;   // cycles with no beat on either side
   localparam int TAIL_CYCLES = 30;     // pipeline is 6 deep, give it plenty

   // shape of the samples inside one random frame
   localparam int STYLE_NOISE = 0;
   localparam int STYLE_RAILS = 1;
   localparam int STYLE_DRIFT = 2;

   localparam logic signed [15:0] S_MAX = 16'sh7fff;
   localparam logic signed [15:0] S_MIN = 16'sh8000;

   // edge weights, oldest tap first; the tail outputs use them mirrored
   localparam int EDGE0_W [TAPS] = '{13, 10, 7, 4, 1, -2, -5};
   localparam int EDGE1_W [TAPS] = '{5, 4, 3, 2, 1, 0, -1};
   localparam int EDGE2_W [TAPS] = '{7, 6, 5, 4, 3, 2, 1};

   typedef struct {
      logic signed [15:0] value;
      logic               fin;     // last sample of the frame
      logic               drain;   // hold this beat back until every result is home
   } sample_beat_type;

   typedef struct {
      logic signed [15:0] smoothed;
      logic               run_last;
   } smoothed_beat_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic [DATA_W-1:0] req_tdata = '0;    // sample
   logic              req_tlast = 1'b0;  // frame_end
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] rsp_tdata;         // smoothed
   logic              rsp_tlast;         // run_last
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;

   sample_beat_type   sample_backlog[$];
   smoothed_beat_type smoothed_due[$];

   // predictor state: sample window (index 6 newest) and fill count of the frame
   logic signed [15:0] win [TAPS];
   int                 frame_fill = 0;

   logic req_taken   = 1'b0;   // sample beat accepted at the last rising edge
   logic tail_phase  = 1'b0;
   int   send_idle   = 0;
   int   recv_stall  = 0;
   int   fails       = 0;
   int   quiet_count = 0;

   seven_point_linear_smoother #(.SAMPLE_BITS(SBITS)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready)
   );

   always #4 clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic logic signed [15:0] clamp16(input longint v);
      if (v > longint'(S_MAX)) return S_MAX;
      if (v < longint'(S_MIN)) return S_MIN;
      return v[15:0];
   endfunction

   // linear-fit edge output over the current window, truncating division
   function automatic logic signed [15:0] edge_fit(input int w [TAPS], input bit mirror,
                                                   input longint divisor);
      longint acc;
      acc = 0;
      for (int i = 0; i < TAPS; i++)
         acc += longint'(w[i]) * longint'(mirror ? win[TAPS-1-i] : win[i]);
      return clamp16(acc / divisor);
   endfunction

   function automatic logic signed [15:0] centered_mean();
      longint acc;
      acc = 0;
      for (int i = 0; i < TAPS; i++)
         acc += longint'(win[i]);
      return clamp16(acc / 64'sd7);
   endfunction

   // one accepted sample: shift the window and queue every smoothed beat it causes
   function automatic void smooth_predict(input logic signed [15:0] s, input logic fin);
      smoothed_beat_type fresh[$];
      smoothed_beat_type b;
      int                prev_fill;
      prev_fill = frame_fill;
      for (int i = 0; i < TAPS - 1; i++)
         win[i] = win[i+1];
      win[TAPS-1] = s;
      if (frame_fill < TAPS)
         frame_fill++;
      b.run_last = 1'b0;
      if (frame_fill < TAPS) begin
         // short frame: held samples come back unchanged, oldest first
         if (fin) begin
            for (int i = TAPS - frame_fill; i < TAPS; i++) begin
               b.smoothed = win[i];
               fresh.push_back(b);
            end
         end
      end else begin
         if (prev_fill < TAPS) begin
            b.smoothed = edge_fit(EDGE0_W, 1'b0, 28); fresh.push_back(b);
            b.smoothed = edge_fit(EDGE1_W, 1'b0, 14); fresh.push_back(b);
            b.smoothed = edge_fit(EDGE2_W, 1'b0, 28); fresh.push_back(b);
         end
         b.smoothed = centered_mean(); fresh.push_back(b);
         if (fin) begin
            b.smoothed = edge_fit(EDGE2_W, 1'b1, 28); fresh.push_back(b);
            b.smoothed = edge_fit(EDGE1_W, 1'b1, 14); fresh.push_back(b);
            b.smoothed = edge_fit(EDGE0_W, 1'b1, 28); fresh.push_back(b);
         end
      end
      if (fin) begin
         if (fresh.size() > 0)
            fresh[fresh.size()-1].run_last = 1'b1;
         frame_fill = 0;
      end
      foreach (fresh[i])
         smoothed_due.push_back(fresh[i]);
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic void queue_sample(input logic signed [15:0] v, input logic fin,
                                        input logic drain);
      sample_beat_type sb;
      sb.value = v;
      sb.fin   = fin;
      sb.drain = drain;
      sample_backlog.push_back(sb);
   endfunction

   function automatic logic signed [15:0] pick_sample(input int style,
                                                      input logic signed [15:0] prev);
      logic signed [15:0] v;
      case (style)
         STYLE_RAILS: v = ($urandom_range(0, 1) == 1) ? S_MAX : S_MIN;
         STYLE_DRIFT: v = prev + 16'($signed($urandom_range(0, 200)) - 100);
         default: begin
            case ($urandom_range(0, 7))
               0:       v = S_MAX;
               1:       v = S_MIN;
               2:       v = 16'($signed($urandom_range(0, 16)) - 8);
               default: v = 16'($urandom);
            endcase
         end
      endcase
      return v;
   endfunction

   // ------------------------------------------------------------------
   // sample driver: changes on the falling edge only
   // ------------------------------------------------------------------
   always @(negedge clock) begin : sample_driver
      sample_beat_type sb;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (req_tvalid && !req_taken) begin
         // beat still on offer, hold it
      end else if (send_idle > 0) begin
         send_idle  <= send_idle - 1;
         req_tvalid <= 1'b0;
      end else if (sample_backlog.size() == 0) begin
         req_tvalid <= 1'b0;
      end else if (sample_backlog[0].drain && smoothed_due.size() != 0) begin
         // sender pause: wait for the output side to run dry
         req_tvalid <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
         send_idle  <= $urandom_range(1, 19) - 1;
         req_tvalid <= 1'b0;
      end else begin
         sb = sample_backlog.pop_front();
         req_tdata  <= DATA_W'(sb.value);
         req_tlast  <= sb.fin;
         req_tvalid <= 1'b1;
      end
   end

   // result side back-pressure in bursts, none near the end
   always @(negedge clock) begin : result_stall
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (recv_stall > 0) begin
         recv_stall <= recv_stall - 1;
         rsp_tready <= 1'b0;
      end else if (!tail_phase && $urandom_range(0, 11) == 0) begin
         recv_stall <= $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // ------------------------------------------------------------------
   // monitor: predicts on sample beats, checks result beats, rising edge
   // ------------------------------------------------------------------
   always @(posedge clock) begin : beat_monitor
      smoothed_beat_type due;
      if (!reset) begin
         if (req_tvalid && req_tready)
            smooth_predict($signed(req_tdata[15:0]), req_tlast);
         if (rsp_tvalid && rsp_tready) begin
            if (smoothed_due.size() == 0) begin
               $error("unexpected result beat: smoothed %0d, run_last %0b",
                      $signed(rsp_tdata[15:0]), rsp_tlast);
               fails++;
            end else begin
               due = smoothed_due.pop_front();
               if ($signed(rsp_tdata[15:0]) !== due.smoothed) begin
                  $error("smoothed: expected %0d, actual %0d",
                         due.smoothed, $signed(rsp_tdata[15:0]));
                  fails++;
               end
               if (rsp_tlast !== due.run_last) begin
                  $error("run_last: expected %0b, actual %0b", due.run_last, rsp_tlast);
                  fails++;
               end
            end
         end
      end
      req_taken  <= req_tvalid && req_tready;
      tail_phase <= sample_backlog.size() < QUIET_ITEMS;
   end

   // watchdog on cycles where neither side moves a beat
   always @(posedge clock) begin : stall_watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_count <= 0;
      end else if (quiet_count >= WD_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         quiet_count <= quiet_count + 1;
      end
   end

   // ------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------
   initial begin : test_sequence
      int                 total;
      int                 len;
      int                 style;
      int                 frame_no;
      logic               drain;
      logic signed [15:0] v;

      foreach (win[i])
         win[i] = '0;

      // directed: single-sample frame at the top rail
      queue_sample(S_MAX, 1'b1, 1'b0);
      // two-sample short frame, bottom rail first
      queue_sample(S_MIN, 1'b0, 1'b0);
      queue_sample(16'sd1, 1'b1, 1'b0);
      // frame of exactly seven: all outputs on the seventh, edge fits past the rails
      for (int k = 0; k < 5; k++)
         queue_sample(S_MAX, 1'b0, 1'b0);
      queue_sample(S_MIN, 1'b0, 1'b0);
      queue_sample(S_MIN, 1'b1, 1'b0);
      // frame of eight, saturating the other way, ends in zero
      for (int k = 0; k < 5; k++)
         queue_sample(S_MIN, 1'b0, 1'b0);
      queue_sample(S_MAX, 1'b0, 1'b0);
      queue_sample(S_MAX, 1'b0, 1'b0);
      queue_sample(16'sd0, 1'b1, 1'b0);
      // three-sample short frame with odd signs
      queue_sample(-16'sd1, 1'b0, 1'b0);
      queue_sample(16'sd1, 1'b0, 1'b0);
      queue_sample(16'sd5, 1'b1, 1'b0);

      // random frames, mostly long enough to reach the centered mean
      total    = 0;
      frame_no = 0;
      while (total < 400) begin
         case ($urandom_range(0, 9))
            0, 1:    len = $urandom_range(1, 6);
            2:       len = TAPS;
            9:       len = $urandom_range(25, 60);
            default: len = $urandom_range(8, 24);
         endcase
         case ($urandom_range(0, 5))
            0:       style = STYLE_RAILS;
            1:       style = STYLE_DRIFT;
            default: style = STYLE_NOISE;
         endcase
         drain = (frame_no == 0) || ($urandom_range(0, 11) == 0);
         v = 16'($urandom);
         for (int k = 0; k < len; k++) begin
            v = pick_sample(style, v);
            queue_sample(v, k == len - 1, drain && k == 0);
         end
         total += len;
         frame_no++;
      end

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (sample_backlog.size() != 0 || req_tvalid)
         @(posedge clock);
      while (smoothed_due.size() != 0)
         @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (fails == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
